### rtl/bpw_pkg.sv
package bpw_pkg;

   localparam int COORD_W    = 12;
   localparam int CHAN_W     = 8;
   localparam int ADDR_W     = 24;
   localparam int WORD_W     = 16;
   localparam int FMT_W      = 9;
   localparam int LIMIT_W    = 13;
   localparam int LINE_W     = 16;
   localparam int BASE_W     = 24;
   localparam int MAP_W      = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;
   localparam int SCALED_W   = 24;
   localparam int PROD_W     = COORD_W + LINE_W;
   localparam int SUM_W      = 30;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = QPTR_W + 1;
   localparam logic [4:0] LEN_MAX = 5'd16;

   localparam logic [FMT_W-1:0]   RED_FORMAT_RST   = 9'd363;
   localparam logic [FMT_W-1:0]   GREEN_FORMAT_RST = 9'd166;
   localparam logic [FMT_W-1:0]   BLUE_FORMAT_RST  = 9'd5;
   localparam logic [LIMIT_W-1:0] WIDTH_LIMIT_RST  = 13'd320;
   localparam logic [LIMIT_W-1:0] HEIGHT_LIMIT_RST = 13'd240;
   localparam logic [LINE_W-1:0]  LINE_BYTES_RST   = 16'd640;
   localparam logic [BASE_W-1:0]  BASE_OFFSET_RST  = 24'd0;
   localparam logic [MAP_W-1:0]   MAP_BYTES_RST    = 25'd153600;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RED_FORMAT   = 3'd0,
      CSR_GREEN_FORMAT = 3'd1,
      CSR_BLUE_FORMAT  = 3'd2,
      CSR_WIDTH_LIMIT  = 3'd3,
      CSR_HEIGHT_LIMIT = 3'd4,
      CSR_LINE_BYTES   = 3'd5,
      CSR_BASE_OFFSET  = 3'd6,
      CSR_MAP_BYTES    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic [CHAN_W-1:0]  red_in;
      logic [CHAN_W-1:0]  green_in;
      logic [CHAN_W-1:0]  blue_in;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] byte_address;
      logic [WORD_W-1:0] pixel_word;
      logic              out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [FMT_W-1:0]   red_format;
      logic [FMT_W-1:0]   green_format;
      logic [FMT_W-1:0]   blue_format;
      logic [LIMIT_W-1:0] width_limit;
      logic [LIMIT_W-1:0] height_limit;
      logic [LINE_W-1:0]  line_bytes;
      logic [BASE_W-1:0]  base_offset;
      logic [MAP_W-1:0]   map_bytes;
   } cfg_type;

   // classified word as it sits in the queue
   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic [CHAN_W-1:0]  red_in;
      logic [CHAN_W-1:0]  green_in;
      logic [CHAN_W-1:0]  blue_in;
      logic               frame_start;
      logic               clipped;
   } entry_type;

   // c * (2^len - 1) as (c << len) - c, length clamped to sixteen
   function automatic logic [SCALED_W-1:0] scale_numer(input logic [CHAN_W-1:0] chan,
                                                        input logic [FMT_W-1:0] fmt);
      logic [4:0]          len;
      logic [SCALED_W-1:0] c_ext;
      len = fmt[4:0];
      if (len > LEN_MAX) begin
         len = LEN_MAX;
      end
      c_ext = {{(SCALED_W-CHAN_W){1'b0}}, chan};
      return (c_ext << len) - c_ext;
   endfunction

   // x / 255: estimate never exceeds the quotient and is at most one short
   function automatic logic [WORD_W-1:0] div255(input logic [SCALED_W-1:0] x);
      logic [SCALED_W:0] n;
      logic [16:0]       q;
      logic [SCALED_W:0] r;
      n = {1'b0, x} + {9'b0, x[23:8]} + {17'b0, x[23:16]};
      q = n[24:8];
      r = {1'b0, x} - ({q, 8'b0} - {8'b0, q});
      if (r >= 25'd255) begin
         q = q + 17'd1;
      end
      return q[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] place(input logic [WORD_W-1:0] q,
                                                input logic [FMT_W-1:0] fmt);
      logic [31:0] w;
      w = {16'b0, q} << fmt[8:5];
      return w[WORD_W-1:0];
   endfunction

endpackage

### rtl/bpw_front.sv
module bpw_front #(
   parameter int COORD_BITS = 12
) (
   input  logic               req_valid,
   input  bpw_pkg::req_type   req_word,
   input  bpw_pkg::cfg_type   cfg,
   input  logic               queue_full,
   output logic               req_stall,
   output logic               push,
   output bpw_pkg::entry_type entry
);

   localparam int CBITS = (COORD_BITS < bpw_pkg::COORD_W) ? COORD_BITS : bpw_pkg::COORD_W;
   localparam logic [bpw_pkg::COORD_W-1:0] CMASK =
      {bpw_pkg::COORD_W{1'b1}} >> (bpw_pkg::COORD_W - CBITS);

   logic [bpw_pkg::COORD_W-1:0] col;
   logic [bpw_pkg::COORD_W-1:0] row;
   logic                        clip;

   assign req_stall = queue_full;

   always_comb begin
      col  = req_word.column & CMASK;
      row  = req_word.row & CMASK;
      clip = ({1'b0, col} >= cfg.width_limit) || ({1'b0, row} >= cfg.height_limit);

      entry.column      = col;
      entry.row         = row;
      entry.red_in      = req_word.red_in;
      entry.green_in    = req_word.green_in;
      entry.blue_in     = req_word.blue_in;
      entry.frame_start = req_word.frame_start;
      entry.clipped     = clip;

      // drop clipped words outright unless they carry a frame start
      push = req_valid && !req_stall && (!clip || req_word.frame_start);
   end

endmodule

### rtl/bpw_queue.sv
module bpw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bpw_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output bpw_pkg::entry_type head
);

   bpw_pkg::entry_type              slot_ff [bpw_pkg::QUEUE_DEPTH];
   logic [bpw_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [bpw_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [bpw_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            do_pop;

   assign full      = (count_ff == bpw_pkg::QCNT_W'(bpw_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/bpw_back.sv
module bpw_back #(
   parameter int ADDR_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  bpw_pkg::cfg_type   cfg,
   input  logic               not_empty,
   input  bpw_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_valid,
   output bpw_pkg::rsp_type   rsp_word,
   input  logic               rsp_stall
);

   localparam int ABITS = (ADDR_BITS < bpw_pkg::ADDR_W) ? ADDR_BITS : bpw_pkg::ADDR_W;
   localparam logic [bpw_pkg::ADDR_W-1:0] AMASK =
      {bpw_pkg::ADDR_W{1'b1}} >> (bpw_pkg::ADDR_W - ABITS);

   typedef struct packed {
      logic [bpw_pkg::SCALED_W-1:0] x_red;
      logic [bpw_pkg::SCALED_W-1:0] x_green;
      logic [bpw_pkg::SCALED_W-1:0] x_blue;
      logic [bpw_pkg::PROD_W-1:0]   prod;
      logic [bpw_pkg::COORD_W-1:0]  column;
      logic                         frame_start;
      logic                         clipped;
   } stage1_type;

   typedef struct packed {
      logic [bpw_pkg::WORD_W-1:0] q_red;
      logic [bpw_pkg::WORD_W-1:0] q_green;
      logic [bpw_pkg::WORD_W-1:0] q_blue;
      logic [bpw_pkg::SUM_W-1:0]  addr;
      logic                       frame_start;
      logic                       clipped;
   } stage2_type;

   logic             advance;
   logic             s1_valid_ff, s1_valid_in;
   stage1_type       s1_ff, s1_in;
   logic             s2_valid_ff, s2_valid_in;
   stage2_type       s2_ff, s2_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bpw_pkg::rsp_type rsp_ff, rsp_in;
   logic             aborted_ff, aborted_in;
   logic             live_abort;
   logic             oor;
   logic [bpw_pkg::WORD_W-1:0] word;

   // whole pipe moves together whenever the output slot can take a word
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign pop       = advance && not_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      s1_valid_in         = advance ? pop : s1_valid_ff;
      s1_in               = s1_ff;
      if (advance) begin
         s1_in.x_red       = bpw_pkg::scale_numer(head.red_in, cfg.red_format);
         s1_in.x_green     = bpw_pkg::scale_numer(head.green_in, cfg.green_format);
         s1_in.x_blue      = bpw_pkg::scale_numer(head.blue_in, cfg.blue_format);
         s1_in.prod        = head.row * cfg.line_bytes;
         s1_in.column      = head.column;
         s1_in.frame_start = head.frame_start;
         s1_in.clipped     = head.clipped;
      end

      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
      s2_in       = s2_ff;
      if (advance) begin
         s2_in.q_red       = bpw_pkg::div255(s1_ff.x_red);
         s2_in.q_green     = bpw_pkg::div255(s1_ff.x_green);
         s2_in.q_blue      = bpw_pkg::div255(s1_ff.x_blue);
         s2_in.addr        = bpw_pkg::SUM_W'(cfg.base_offset)
                           + bpw_pkg::SUM_W'(s1_ff.prod)
                           + bpw_pkg::SUM_W'({s1_ff.column, 1'b0});
         s2_in.frame_start = s1_ff.frame_start;
         s2_in.clipped     = s1_ff.clipped;
      end

      word = bpw_pkg::place(s2_ff.q_red, cfg.red_format)
           | bpw_pkg::place(s2_ff.q_green, cfg.green_format)
           | bpw_pkg::place(s2_ff.q_blue, cfg.blue_format);
      oor  = ({1'b0, s2_ff.addr} + 31'd2) > {6'b0, cfg.map_bytes};

      // frame start clears the latch before this word is judged
      live_abort   = aborted_ff && !s2_ff.frame_start;
      aborted_in   = aborted_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b0;
         if (s2_valid_ff) begin
            aborted_in = live_abort;
            if (!live_abort && !s2_ff.clipped) begin
               rsp_valid_in        = 1'b1;
               rsp_in.byte_address = s2_ff.addr[bpw_pkg::ADDR_W-1:0] & AMASK;
               rsp_in.pixel_word   = oor ? '0 : word;
               rsp_in.out_of_range = oor;
               aborted_in          = oor;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         aborted_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         aborted_ff   <= aborted_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      s2_ff  <= s2_in;
      rsp_ff <= rsp_in;
   end

endmodule

### rtl/bgra_to_packed_pixel_writer_unit.sv
// BGRA to packed pixel writer.
// Input channel (req_): one source pixel per word - column, row, 8-bit red,
// green and blue, and a frame-start mark. A word is taken on a rising edge
// with req_valid high and req_stall low.
// Result channel (rsp_): at most one word per pixel - destination byte
// address, packed 16-bit pixel and an out-of-range flag. Clipped pixels and
// pixels of an aborted frame give no word. A write past map_bytes gives one
// word with out_of_range set and pixel_word zero, and mutes the frame until
// the next frame start.
// Configuration (csr_): write csr_data to register csr_index while
// csr_write_enable is high; only change it while the block is idle.
// An accepted word passes the queue, then the stage-one, stage-two and
// result registers. Throughput: one word per cycle while rsp_stall is low;
// set by three back stages: multiplier, divide-by-255, pack and bound check.
// Reset (synchronous) restores register defaults, empties the queue and
// clears the abort latch. When the receiver stalls, the back pipe holds and
// the four-entry queue fills; req_stall rises once it is full.
module bgra_to_packed_pixel_writer_unit #(
   parameter int ADDR_BITS  = 24,
   parameter int COORD_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bpw_pkg::req_type                  req_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bpw_pkg::rsp_type                  rsp_word,
   input  logic                              csr_write_enable,
   input  logic [bpw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bpw_pkg::CSR_DATA_W-1:0]    csr_data
);

   bpw_pkg::cfg_type   cfg_ff, cfg_in;
   logic               push;
   bpw_pkg::entry_type push_entry;
   logic               queue_full;
   logic               queue_not_empty;
   bpw_pkg::entry_type head;
   logic               pop;

   // register file: each write lands in one field, truncated to its width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (bpw_pkg::csr_index_type'(csr_index))
            bpw_pkg::CSR_RED_FORMAT:   cfg_in.red_format   = csr_data[bpw_pkg::FMT_W-1:0];
            bpw_pkg::CSR_GREEN_FORMAT: cfg_in.green_format = csr_data[bpw_pkg::FMT_W-1:0];
            bpw_pkg::CSR_BLUE_FORMAT:  cfg_in.blue_format  = csr_data[bpw_pkg::FMT_W-1:0];
            bpw_pkg::CSR_WIDTH_LIMIT:  cfg_in.width_limit  = csr_data[bpw_pkg::LIMIT_W-1:0];
            bpw_pkg::CSR_HEIGHT_LIMIT: cfg_in.height_limit = csr_data[bpw_pkg::LIMIT_W-1:0];
            bpw_pkg::CSR_LINE_BYTES:   cfg_in.line_bytes   = csr_data[bpw_pkg::LINE_W-1:0];
            bpw_pkg::CSR_BASE_OFFSET:  cfg_in.base_offset  = csr_data[bpw_pkg::BASE_W-1:0];
            bpw_pkg::CSR_MAP_BYTES:    cfg_in.map_bytes    = csr_data[bpw_pkg::MAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_format   <= bpw_pkg::RED_FORMAT_RST;
         cfg_ff.green_format <= bpw_pkg::GREEN_FORMAT_RST;
         cfg_ff.blue_format  <= bpw_pkg::BLUE_FORMAT_RST;
         cfg_ff.width_limit  <= bpw_pkg::WIDTH_LIMIT_RST;
         cfg_ff.height_limit <= bpw_pkg::HEIGHT_LIMIT_RST;
         cfg_ff.line_bytes   <= bpw_pkg::LINE_BYTES_RST;
         cfg_ff.base_offset  <= bpw_pkg::BASE_OFFSET_RST;
         cfg_ff.map_bytes    <= bpw_pkg::MAP_BYTES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, mask coordinates, clip against the visible window
   bpw_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_valid  (req_valid),
      .req_word   (req_word),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push),
      .entry      (push_entry)
   );

   // queue: decouple the front from back-pressure on the result side
   bpw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   // back: scale and pack channels, form the address, police the map bound
   bpw_back #(
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .not_empty (queue_not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .rsp_stall (rsp_stall)
   );

endmodule

### rtl/bpw_checker.sv
module bpw_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input bpw_pkg::rsp_type rsp_word
);

   // nothing may be presented straight out of reset
   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   // queue is empty after reset, so the input must be open
   a_req_open_after_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

   // a bound violation never carries pixel data
   a_oor_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.out_of_range |-> rsp_word.pixel_word == '0)
      else $error("out-of-range word carries pixel data");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

endmodule

bind bgra_to_packed_pixel_writer_unit bpw_checker u_bpw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

### dv/bgra_to_packed_pixel_writer_unit_test.sv
`timescale 1ns / 100ps

module bgra_to_packed_pixel_writer_unit_test;

   localparam int QUIET_LIMIT   = 4000; // cycles with no word moving before giving up
   localparam int HOLD_CYCLES   = 60;   // long receiver hold-off that fills the block
   localparam int SETTLE_CYCLES = 16;   // unstalled cycles to flush silent pixels
   localparam int REPORT_MAX    = 20;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   bpw_pkg::req_type               req_word = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   bpw_pkg::rsp_type               rsp_word;
   logic                           csr_write_enable = 1'b0;
   bpw_pkg::csr_index_type         csr_index = bpw_pkg::CSR_RED_FORMAT;
   logic [bpw_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // pixels waiting to be offered, and the writes they are predicted to cause
   bpw_pkg::req_type pending_pixels[$];
   bpw_pkg::rsp_type expected_writes[$];

   bpw_pkg::cfg_type shadow_cfg;   // register copy, tracked from the csr port
   logic             frame_muted;  // copy of the sticky abort latch

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int hold_requests     = 0;
   int holds_done        = 0;
   int hold_left         = 0;
   int failures          = 0;
   int pixels_taken      = 0;
   int silent_pixels     = 0;
   int writes_seen       = 0;
   int range_errors_seen = 0;
   int settings_loaded   = 0;
   int quiet_cycles      = 0;

   bgra_to_packed_pixel_writer_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Scale one 8-bit channel to c * (2^len - 1) / 255, truncating, then shift to its offset.
   function automatic logic [63:0] fit_channel(input logic [bpw_pkg::CHAN_W-1:0] chan,
                                               input logic [bpw_pkg::FMT_W-1:0] fmt);
      logic [4:0]  len;
      logic [63:0] top;
      len = fmt[4:0];
      if (len > bpw_pkg::LEN_MAX) begin
         len = bpw_pkg::LEN_MAX;
      end
      if (len == 5'd0) begin
         return 64'd0;
      end
      top = (64'd1 << len) - 64'd1;
      return ((64'(chan) * top) / 64'd255) << fmt[8:5];
   endfunction

   // Work out the write one accepted pixel causes, if any, and queue it.
   task automatic predict_pixel_write(input bpw_pkg::req_type px);
      logic [63:0]      packed_word;
      logic [63:0]      addr;
      bpw_pkg::rsp_type wr;
      // frame start clears the latch before anything else is decided
      if (px.frame_start) begin
         frame_muted = 1'b0;
      end
      if (frame_muted || px.column >= shadow_cfg.width_limit
          || px.row >= shadow_cfg.height_limit) begin
         silent_pixels++;
         return;
      end
      packed_word = fit_channel(px.red_in, shadow_cfg.red_format)
                  | fit_channel(px.green_in, shadow_cfg.green_format)
                  | fit_channel(px.blue_in, shadow_cfg.blue_format);
      // full precision: no wrap before the bound check
      addr = 64'(shadow_cfg.base_offset) + 64'(px.row) * 64'(shadow_cfg.line_bytes)
           + 64'(px.column) * 64'd2;
      wr.byte_address = addr[bpw_pkg::ADDR_W-1:0];
      if (addr + 64'd2 > 64'(shadow_cfg.map_bytes)) begin
         frame_muted     = 1'b1;
         wr.pixel_word   = '0;
         wr.out_of_range = 1'b1;
      end else begin
         wr.pixel_word   = packed_word[bpw_pkg::WORD_W-1:0];
         wr.out_of_range = 1'b0;
      end
      expected_writes.push_back(wr);
   endtask

   function automatic bpw_pkg::req_type make_pixel(input int col, input int row,
                                                   input int red, input int green,
                                                   input int blue, input bit first);
      bpw_pkg::req_type px;
      px.column      = bpw_pkg::COORD_W'(col);
      px.row         = bpw_pkg::COORD_W'(row);
      px.red_in      = bpw_pkg::CHAN_W'(red);
      px.green_in    = bpw_pkg::CHAN_W'(green);
      px.blue_in     = bpw_pkg::CHAN_W'(blue);
      px.frame_start = first;
      return px;
   endfunction

   task automatic put_reg(input bpw_pkg::csr_index_type idx,
                          input logic [bpw_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value;
   endtask

   // Write every register on back-to-back edges; only called while the block is idle.
   task automatic load_setting(input bpw_pkg::cfg_type s);
      put_reg(bpw_pkg::CSR_RED_FORMAT,   bpw_pkg::CSR_DATA_W'(s.red_format));
      put_reg(bpw_pkg::CSR_GREEN_FORMAT, bpw_pkg::CSR_DATA_W'(s.green_format));
      put_reg(bpw_pkg::CSR_BLUE_FORMAT,  bpw_pkg::CSR_DATA_W'(s.blue_format));
      put_reg(bpw_pkg::CSR_WIDTH_LIMIT,  bpw_pkg::CSR_DATA_W'(s.width_limit));
      put_reg(bpw_pkg::CSR_HEIGHT_LIMIT, bpw_pkg::CSR_DATA_W'(s.height_limit));
      put_reg(bpw_pkg::CSR_LINE_BYTES,   bpw_pkg::CSR_DATA_W'(s.line_bytes));
      put_reg(bpw_pkg::CSR_BASE_OFFSET,  bpw_pkg::CSR_DATA_W'(s.base_offset));
      put_reg(bpw_pkg::CSR_MAP_BYTES,    bpw_pkg::CSR_DATA_W'(s.map_bytes));
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_loaded++;
   endtask

   // Wait until every pixel is taken and every write has come back, then let
   // clipped or muted pixels still in flight drain out.  Sample at the falling
   // edge so the driver's queue pops have settled.
   task automatic settle_phase();
      int quiet;
      quiet = 0;
      while (pending_pixels.size() != 0 || req_valid || expected_writes.size() != 0) begin
         @(negedge clock);
      end
      while (quiet < SETTLE_CYCLES) begin
         @(negedge clock);
         if (!rsp_stall) begin
            quiet++;
         end
      end
   endtask

   // Track register writes exactly as the block sees them.
   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg <= '{bpw_pkg::RED_FORMAT_RST, bpw_pkg::GREEN_FORMAT_RST,
                         bpw_pkg::BLUE_FORMAT_RST, bpw_pkg::WIDTH_LIMIT_RST,
                         bpw_pkg::HEIGHT_LIMIT_RST, bpw_pkg::LINE_BYTES_RST,
                         bpw_pkg::BASE_OFFSET_RST, bpw_pkg::MAP_BYTES_RST};
      end else if (csr_write_enable) begin
         case (csr_index)
            bpw_pkg::CSR_RED_FORMAT:
               shadow_cfg.red_format   <= csr_data[bpw_pkg::FMT_W-1:0];
            bpw_pkg::CSR_GREEN_FORMAT:
               shadow_cfg.green_format <= csr_data[bpw_pkg::FMT_W-1:0];
            bpw_pkg::CSR_BLUE_FORMAT:
               shadow_cfg.blue_format  <= csr_data[bpw_pkg::FMT_W-1:0];
            bpw_pkg::CSR_WIDTH_LIMIT:
               shadow_cfg.width_limit  <= csr_data[bpw_pkg::LIMIT_W-1:0];
            bpw_pkg::CSR_HEIGHT_LIMIT:
               shadow_cfg.height_limit <= csr_data[bpw_pkg::LIMIT_W-1:0];
            bpw_pkg::CSR_LINE_BYTES:
               shadow_cfg.line_bytes   <= csr_data[bpw_pkg::LINE_W-1:0];
            bpw_pkg::CSR_BASE_OFFSET:
               shadow_cfg.base_offset  <= csr_data[bpw_pkg::BASE_W-1:0];
            bpw_pkg::CSR_MAP_BYTES:
               shadow_cfg.map_bytes    <= csr_data[bpw_pkg::MAP_W-1:0];
            default: ;
         endcase
      end
   end

   // Pixel driver: predict on acceptance, then offer the next word or idle.
   // A stalled word is held untouched; the idle choice is made only once the
   // slot is free, so valid never looks at stall.
   always @(posedge clock) begin
      logic             next_valid;
      bpw_pkg::req_type next_word;
      if (reset) begin
         frame_muted = 1'b0;
         req_valid  <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predict_pixel_write(req_word);
            pixels_taken++;
         end
         next_valid = 1'b0;
         next_word  = req_word;
         if (pending_pixels.size() != 0
             && $urandom_range(0, 99) >= sender_idle_pct) begin
            next_valid = 1'b1;
            next_word  = pending_pixels.pop_front();
         end
         req_valid <= next_valid;
         req_word  <= next_word;
      end
   end

   // Write monitor: check each accepted word against the oldest prediction,
   // then pick the stall for the next cycle.
   always @(posedge clock) begin
      bpw_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            writes_seen++;
            if (rsp_word.out_of_range === 1'b1) begin
               range_errors_seen++;
            end
            if (expected_writes.size() == 0) begin
               failures++;
               if (failures <= REPORT_MAX) begin
                  $display("%0t: unexpected write: expected none, got addr %h word %h oor %b",
                           $time, rsp_word.byte_address, rsp_word.pixel_word,
                           rsp_word.out_of_range);
               end
            end else begin
               want = expected_writes.pop_front();
               if (rsp_word.byte_address !== want.byte_address
                   || rsp_word.pixel_word !== want.pixel_word
                   || rsp_word.out_of_range !== want.out_of_range) begin
                  failures++;
                  if (failures <= REPORT_MAX) begin
                     $display("%0t: write mismatch: expected addr %h word %h oor %b,",
                              $time, want.byte_address, want.pixel_word,
                              want.out_of_range, " got addr %h word %h oor %b",
                              rsp_word.byte_address, rsp_word.pixel_word,
                              rsp_word.out_of_range);
                  end
               end
            end
         end
         // start a long hold-off when asked; count it down here
         if (hold_left == 0 && holds_done < hold_requests) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
         end
      end
   end

   // Watchdog: give up when no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no traffic for %0d cycles", $time, QUIET_LIMIT);
         $display("bgra_to_packed_pixel_writer_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int               p;
      int               k;
      int               made;
      int               frame_len;
      int               phase_items;
      bit               broken;
      bpw_pkg::req_type px;
      bpw_pkg::cfg_type cur;
      longint           span;
      longint           map_pick;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 8;
      receiver_idle_pct = 55;

      // Directed, default geometry: corners, clipping on each axis, pure channels.
      load_setting('{bpw_pkg::RED_FORMAT_RST, bpw_pkg::GREEN_FORMAT_RST,
                     bpw_pkg::BLUE_FORMAT_RST, bpw_pkg::WIDTH_LIMIT_RST,
                     bpw_pkg::HEIGHT_LIMIT_RST, bpw_pkg::LINE_BYTES_RST,
                     bpw_pkg::BASE_OFFSET_RST, bpw_pkg::MAP_BYTES_RST});
      pending_pixels.push_back(make_pixel(0, 0, 0, 0, 0, 1'b1));
      pending_pixels.push_back(make_pixel(319, 239, 255, 255, 255, 1'b0)); // last byte of map
      pending_pixels.push_back(make_pixel(320, 0, 255, 255, 255, 1'b0));   // clipped column
      pending_pixels.push_back(make_pixel(0, 240, 255, 255, 255, 1'b0));   // clipped row
      pending_pixels.push_back(make_pixel(4095, 4095, 255, 255, 255, 1'b0));
      pending_pixels.push_back(make_pixel(1, 0, 255, 0, 0, 1'b0));
      pending_pixels.push_back(make_pixel(2, 0, 0, 255, 0, 1'b0));
      pending_pixels.push_back(make_pixel(3, 0, 0, 0, 255, 1'b0));
      pending_pixels.push_back(make_pixel(100, 100, 128, 127, 1, 1'b0));
      pending_pixels.push_back(make_pixel(200, 50, 170, 85, 255, 1'b1));
      settle_phase();

      // Directed, odd formats: red length clamped to sixteen, green zero length,
      // blue spilling past bit 15; the map ends exactly at the top of the
      // address space, so the compare must not wrap.
      load_setting('{9'd31, 9'd480, 9'd496, 13'd4000, 13'd4096, 16'd65535,
                     24'hFFFF00, 25'h1000000});
      pending_pixels.push_back(make_pixel(0, 0, 255, 255, 255, 1'b1));
      pending_pixels.push_back(make_pixel(127, 0, 200, 10, 77, 1'b0));     // just fits
      pending_pixels.push_back(make_pixel(128, 0, 255, 255, 255, 1'b0));   // past map, abort
      pending_pixels.push_back(make_pixel(0, 0, 255, 255, 255, 1'b0));     // muted
      pending_pixels.push_back(make_pixel(4095, 4095, 0, 0, 0, 1'b0));     // muted
      pending_pixels.push_back(make_pixel(5, 0, 1, 2, 3, 1'b1));           // frame restarts
      pending_pixels.push_back(make_pixel(0, 1, 9, 9, 9, 1'b0));           // past map again
      pending_pixels.push_back(make_pixel(4000, 0, 9, 9, 9, 1'b1));        // clipped, clears latch
      pending_pixels.push_back(make_pixel(1, 0, 254, 0, 128, 1'b0));
      pending_pixels.push_back(make_pixel(4095, 0, 9, 9, 9, 1'b0));        // clipped, no abort
      pending_pixels.push_back(make_pixel(2, 0, 1, 128, 1, 1'b0));
      pending_pixels.push_back(make_pixel(10, 4095, 255, 0, 255, 1'b0));   // far past map
      settle_phase();

      // Random phases, each under its own register setting.
      for (p = 0; p < 8; p++) begin
         case (p * 3 / 8)
            0: begin
               sender_idle_pct   = 8;
               receiver_idle_pct = 55;
            end
            1: begin
               sender_idle_pct   = 55;
               receiver_idle_pct = 8;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase

         cur.red_format   = bpw_pkg::FMT_W'($urandom_range(0, 511));
         cur.green_format = bpw_pkg::FMT_W'($urandom_range(0, 511));
         cur.blue_format  = bpw_pkg::FMT_W'($urandom_range(0, 511));
         phase_items      = 160;
         case (p)
            0: begin
               // small frame, map cut somewhere inside it
               cur.width_limit  = 13'd64;
               cur.height_limit = 13'd48;
               cur.line_bytes   = 16'd128;
               cur.base_offset  = bpw_pkg::BASE_W'($urandom_range(0, 4095));
               cur.map_bytes    = bpw_pkg::MAP_W'(cur.base_offset
                                                  + $urandom_range(0, 48 * 128 + 2));
            end
            1: begin
               // widest geometry at the top of memory: every write is out of range
               cur.width_limit  = 13'd4096;
               cur.height_limit = 13'd4096;
               cur.line_bytes   = 16'hFFFF;
               cur.base_offset  = 24'hFFFFFF;
               cur.map_bytes    = 25'h1000000;
               phase_items      = 80;
            end
            2: begin
               // single pixel, empty map, all channels zero length
               cur.red_format   = '0;
               cur.green_format = '0;
               cur.blue_format  = '0;
               cur.width_limit  = 13'd1;
               cur.height_limit = 13'd1;
               cur.line_bytes   = 16'd0;
               cur.base_offset  = 24'd0;
               cur.map_bytes    = 25'd0;
               phase_items      = 80;
            end
            3: begin
               // zero width: everything clipped
               cur.width_limit  = 13'd0;
               cur.height_limit = 13'd4096;
               cur.line_bytes   = bpw_pkg::LINE_W'($urandom);
               cur.base_offset  = bpw_pkg::BASE_W'($urandom);
               cur.map_bytes    = 25'h1000000;
               phase_items      = 40;
            end
            5: begin
               // every format field at its top, zero line pitch
               cur.red_format   = 9'd511;
               cur.green_format = 9'd511;
               cur.blue_format  = 9'd511;
               cur.width_limit  = 13'd200;
               cur.height_limit = 13'd150;
               cur.line_bytes   = 16'd0;
               cur.base_offset  = bpw_pkg::BASE_W'($urandom_range(0, 24'hFFF000));
               cur.map_bytes    = bpw_pkg::MAP_W'(cur.base_offset + $urandom_range(2, 400));
            end
            6: begin
               // plain 565 layout on the reset geometry
               cur.red_format   = 9'd357;
               cur.green_format = 9'd166;
               cur.blue_format  = 9'd5;
               cur.width_limit  = bpw_pkg::WIDTH_LIMIT_RST;
               cur.height_limit = bpw_pkg::HEIGHT_LIMIT_RST;
               cur.line_bytes   = bpw_pkg::LINE_BYTES_RST;
               cur.base_offset  = bpw_pkg::BASE_OFFSET_RST;
               cur.map_bytes    = bpw_pkg::MAP_BYTES_RST;
               phase_items      = 180;
            end
            default: begin
               // anything goes; phase 7 keeps the frame narrow so the map cut lands inside it
               if (p == 4) begin
                  cur.width_limit  = bpw_pkg::LIMIT_W'($urandom_range(1, 4096));
                  cur.height_limit = bpw_pkg::LIMIT_W'($urandom_range(1, 4096));
                  cur.line_bytes   = bpw_pkg::LINE_W'($urandom);
               end else begin
                  cur.width_limit  = bpw_pkg::LIMIT_W'($urandom_range(1, 512));
                  cur.height_limit = bpw_pkg::LIMIT_W'($urandom_range(1, 512));
                  cur.line_bytes   = bpw_pkg::LINE_W'($urandom_range(0, 2048));
               end
               cur.base_offset = bpw_pkg::BASE_W'($urandom);
               span = longint'(cur.height_limit) * longint'(cur.line_bytes)
                    + 2 * longint'(cur.width_limit);
               map_pick = longint'(cur.base_offset)
                        + longint'($urandom_range(0, int'(span > 32'h7FFFFFFF ? 32'h7FFFFFFF
                                                                               : span)));
               if (map_pick > 64'h1000000) begin
                  map_pick = 64'h1000000;
               end
               cur.map_bytes = bpw_pkg::MAP_W'(map_pick);
               phase_items   = 180;
            end
         endcase
         load_setting(cur);

         // Mostly well-formed frames of visible pixels; some noise pixels with
         // any coordinate and a random frame mark, and some frames without a start.
         made = 0;
         while (made < phase_items) begin
            frame_len = $urandom_range(1, 40);
            if (frame_len > phase_items - made) begin
               frame_len = phase_items - made;
            end
            broken    = ($urandom_range(0, 99) < 6);
            for (k = 0; k < frame_len; k++) begin
               px.red_in   = bpw_pkg::CHAN_W'($urandom);
               px.green_in = bpw_pkg::CHAN_W'($urandom);
               px.blue_in  = bpw_pkg::CHAN_W'($urandom);
               if ($urandom_range(0, 99) < 12 || cur.width_limit == 0
                   || cur.height_limit == 0) begin
                  px.column      = bpw_pkg::COORD_W'($urandom);
                  px.row         = bpw_pkg::COORD_W'($urandom);
                  px.frame_start = 1'($urandom);
               end else begin
                  px.column      = bpw_pkg::COORD_W'($urandom_range(0, cur.width_limit - 1));
                  px.row         = bpw_pkg::COORD_W'($urandom_range(0, cur.height_limit - 1));
                  px.frame_start = (k == 0) && !broken;
               end
               pending_pixels.push_back(px);
               made++;
            end
         end

         // hold the receiver off for a long stretch while pixels keep coming
         if (p == 1 || p == 6) begin
            hold_requests++;
         end
         settle_phase();
      end

      if (expected_writes.size() != 0) begin
         failures++;
         $display("%0t: %0d predicted writes never arrived,", $time, expected_writes.size(),
                  " oldest expected addr %h word %h oor %b, got none",
                  expected_writes[0].byte_address, expected_writes[0].pixel_word,
                  expected_writes[0].out_of_range);
      end

      $display("Covered %0d pixels under %0d register settings, %0d of them clipped or muted.",
               pixels_taken, settings_loaded, silent_pixels);
      $display("Checked %0d writes, %0d of them past the map; %0d mismatches.",
               writes_seen, range_errors_seen, failures);
      if (failures == 0) begin
         $display("bgra_to_packed_pixel_writer_unit verification clean");
      end else begin
         $display("bgra_to_packed_pixel_writer_unit verification failed");
      end
      $finish;
   end

endmodule
